// ----- rtl/pgmap_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the four-level page table mapper.
// No dependencies; every other file imports this package.
package pgmap_pkg;

    // Table pool geometry
    localparam int TABLE_COUNT = 16;
    localparam int IDX_W       = 9;
    localparam int ENTRIES     = 1 << IDX_W;
    localparam int TBL_W       = $clog2(TABLE_COUNT);
    localparam int NFREE_W     = $clog2(TABLE_COUNT + 1);
    localparam int MEM_AW      = TBL_W + IDX_W;
    localparam int MEM_DEPTH   = TABLE_COUNT * ENTRIES;

    // Address and entry formats
    localparam int ADDR_W      = 48;
    localparam int FRAME_W     = 36;
    localparam int PAGE_SHIFT  = 12;
    localparam int ENTRY_W     = 64;
    localparam int FLAGS_W     = 8;

    // Configuration port
    localparam int CFG_AW      = 3;
    localparam int PDATA_W     = 64;
    localparam logic [CFG_AW-1:0] REG_POOL_BASE = 3'd0;

    // Walk levels
    localparam logic [1:0] LVL_TOP      = 2'd0;
    localparam logic [1:0] LVL_UPPER    = 2'd1;
    localparam logic [1:0] LVL_LAST_DIR = 2'd2;
    localparam logic [1:0] LVL_LEAF     = 2'd3;

    // Item modes
    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_XLATE = 1'b1;

    localparam int PRESENT_BIT = 0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_EXHAUST  = 2'd2
    } t_status;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic               we;
        logic [MEM_AW-1:0]  addr;
        logic [ENTRY_W-1:0] wdata;
    } t_mem_req;

    function automatic logic [IDX_W-1:0] level_index(input logic [ADDR_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_TOP:      idx = va[47:39];
            LVL_UPPER:    idx = va[38:30];
            LVL_LAST_DIR: idx = va[29:21];
            default:      idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ----- rtl/pgmap_req_if.sv -----
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with one map or translate item.
// Depends on pgmap_pkg for field widths.
interface pgmap_req_if import pgmap_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [ADDR_W-1:0]  virt_addr;
    logic [ADDR_W-1:0]  phys_addr_in;
    logic [FLAGS_W-1:0] entry_flags;

    modport source (output valid, mode, virt_addr, phys_addr_in, entry_flags, input ready);
    modport sink   (input valid, mode, virt_addr, phys_addr_in, entry_flags, output ready);
endinterface

// ----- rtl/pgmap_rsp_if.sv -----
`timescale 1ns / 1ps
// Response channel: valid/ready handshake with one result per item.
// Depends on pgmap_pkg for field widths and the status type.
interface pgmap_rsp_if import pgmap_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] phys_addr_out;
    t_status           status;

    modport source (output valid, phys_addr_out, status, input ready);
    modport sink   (input valid, phys_addr_out, status, output ready);
endinterface

// ----- rtl/pgmap_alu.sv -----
`timescale 1ns / 1ps
// Shared frame-number adder/subtractor used by the walk sequencer.
// Depends on pgmap_pkg.
module pgmap_alu import pgmap_pkg::*; (
    input  t_alu_op            i_op,
    input  logic [FRAME_W-1:0] i_a,
    input  logic [FRAME_W-1:0] i_b,
    output logic [FRAME_W-1:0] o_y
);

    // Sum wraps modulo 2^36 as frame numbers do
    always_comb begin
        case (i_op)
            OP_SUB:  o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

// ----- rtl/pgmap_store.sv -----
`timescale 1ns / 1ps
// Single-port page table store: one write or one read per cycle,
// registered read data. Depends on pgmap_pkg.
module pgmap_store import pgmap_pkg::*; (
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pgmap_cfg.sv -----
`timescale 1ns / 1ps
// APB-style register slave holding the table pool base frame.
// Depends on pgmap_pkg.
module pgmap_cfg import pgmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [FRAME_W-1:0] o_pool_base
);

    logic [FRAME_W-1:0] r_pool_base;
    logic [FRAME_W-1:0] n_pool_base;

    always_comb begin
        n_pool_base = r_pool_base;
        if (psel && penable && pwrite && (paddr == REG_POOL_BASE)) begin
            n_pool_base = pwdata[FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else begin
            r_pool_base <= n_pool_base;
        end
    end

    always_comb begin
        if (paddr == REG_POOL_BASE) begin
            prdata = PDATA_W'(r_pool_base);
        end else begin
            prdata = '0;
        end
    end

    assign pready      = 1'b1;
    assign o_pool_base = r_pool_base;

endmodule

// ----- rtl/pgmap_walker.sv -----
`timescale 1ns / 1ps
// Walk sequencer: clear pass, four-level walk, table allocation, leaf access
// and the result register. Depends on pgmap_pkg, pgmap_alu, both channel interfaces.
module pgmap_walker import pgmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pgmap_req_if.sink          i_req,
    pgmap_rsp_if.source        o_rsp,
    input  logic [FRAME_W-1:0] i_pool_base,
    output t_mem_req           o_mem,
    input  logic [ENTRY_W-1:0] i_rdata
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_ALLOC = 8'b0001_0000,
        S_LEAF  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000
    } t_state;

    t_state              r_state, n_state;
    logic [MEM_AW-1:0]   r_clr_cnt, n_clr_cnt;
    logic                r_mode, n_mode;
    logic [ADDR_W-1:0]   r_va, n_va;
    logic [ADDR_W-1:0]   r_pa, n_pa;
    logic [FLAGS_W-1:0]  r_flags, n_flags;
    logic [1:0]          r_level, n_level;
    logic [TBL_W-1:0]    r_tbl, n_tbl;
    logic [NFREE_W-1:0]  r_next_free, n_next_free;
    logic [ADDR_W-1:0]   r_res_phys, n_res_phys;
    t_status             r_res_status, n_res_status;
    logic                r_ov, n_ov;
    logic [ADDR_W-1:0]   r_o_phys, n_o_phys;
    t_status             r_o_status, n_o_status;

    t_alu_op             alu_op;
    logic [FRAME_W-1:0]  alu_a;
    logic [FRAME_W-1:0]  alu_b;
    logic [FRAME_W-1:0]  alu_y;
    logic [1:0]          need;
    logic                pool_short;
    logic                misaligned;
    logic                load_out;

    // Shared adder: frame - base on a present entry, base + fresh table on allocation
    always_comb begin
        if (r_state == S_CHECK) begin
            alu_op = OP_SUB;
            alu_a  = i_rdata[ADDR_W-1:PAGE_SHIFT];
            alu_b  = i_pool_base;
        end else begin
            alu_op = OP_ADD;
            alu_a  = i_pool_base;
            alu_b  = FRAME_W'(r_next_free);
        end
    end

    pgmap_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign need       = LVL_LEAF - r_level;
    assign pool_short = ((NFREE_W + 1)'(r_next_free) + (NFREE_W + 1)'(need))
                        > (NFREE_W + 1)'(TABLE_COUNT);
    assign misaligned = (i_req.mode == MODE_MAP) &&
                        ((i_req.virt_addr[PAGE_SHIFT-1:0] != '0) ||
                         (i_req.phys_addr_in[PAGE_SHIFT-1:0] != '0));
    assign load_out   = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    // Store port
    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.addr  = {r_tbl, level_index(r_va, r_level)};
        o_mem.wdata = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we   = 1'b1;
                o_mem.addr = r_clr_cnt;
            end
            S_ALLOC: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = {{(ENTRY_W - ADDR_W){1'b0}}, alu_y,
                               {(PAGE_SHIFT - 1){1'b0}}, 1'b1};
            end
            S_LEAF: begin
                o_mem.we    = (r_mode == MODE_MAP);
                o_mem.wdata = ENTRY_W'(r_pa | ADDR_W'(r_flags));
            end
            default: begin
                o_mem.we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_mode       = r_mode;
        n_va         = r_va;
        n_pa         = r_pa;
        n_flags      = r_flags;
        n_level      = r_level;
        n_tbl        = r_tbl;
        n_next_free  = r_next_free;
        n_res_phys   = r_res_phys;
        n_res_status = r_res_status;
        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode     = i_req.mode;
                    n_va       = i_req.virt_addr;
                    n_pa       = i_req.phys_addr_in;
                    n_flags    = i_req.entry_flags;
                    n_level    = LVL_TOP;
                    n_tbl      = '0;
                    n_res_phys = '0;
                    if (misaligned) begin
                        n_res_status = ST_MISALIGN;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_level == LVL_LEAF) begin
                    n_res_phys   = {i_rdata[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else if (i_rdata[PRESENT_BIT]) begin
                    if (alu_y >= FRAME_W'(r_next_free)) begin
                        n_res_status = ST_EXHAUST;
                        n_state      = S_DONE;
                    end else begin
                        n_tbl   = alu_y[TBL_W-1:0];
                        n_level = r_level + 1'b1;
                        n_state = (r_level == LVL_LAST_DIR) ? S_LEAF : S_READ;
                    end
                end else if (pool_short) begin
                    n_res_status = ST_EXHAUST;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                n_next_free = r_next_free + 1'b1;
                n_tbl       = r_next_free[TBL_W-1:0];
                n_level     = r_level + 1'b1;
                if (r_level == LVL_LAST_DIR) begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                if (r_mode == MODE_MAP) begin
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_ov       = r_ov;
        n_o_phys   = r_o_phys;
        n_o_status = r_o_status;
        if (load_out) begin
            n_ov       = 1'b1;
            n_o_phys   = r_res_phys;
            n_o_status = r_res_status;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_next_free <= NFREE_W'(1);
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_next_free <= n_next_free;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_va         <= n_va;
        r_pa         <= n_pa;
        r_flags      <= n_flags;
        r_level      <= n_level;
        r_tbl        <= n_tbl;
        r_res_phys   <= n_res_phys;
        r_res_status <= n_res_status;
        r_o_phys     <= n_o_phys;
        r_o_status   <= n_o_status;
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_ov;
    assign o_rsp.phys_addr_out = r_o_phys;
    assign o_rsp.status        = r_o_status;

`ifndef SYNTH
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NFREE_W'(TABLE_COUNT))
        else $error("allocator ran past the pool");

    a_alloc_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |=> (r_next_free == $past(r_next_free) + 1'b1))
        else $error("allocation did not advance the allocator");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.phys_addr_out == '0))
        else $error("failed item returned an address");

    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

// ----- rtl/four_level_page_table_mapper.sv -----
`timescale 1ns / 1ps
// Top level of the four-level page table mapper: register slave, walk
// sequencer and table store. Depends on pgmap_pkg, interfaces, pgmap_* modules.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  i_req   | in        | valid/ready          | mode, virt_addr, phys_addr_in, entry_flags
//  o_rsp   | out       | valid/ready          | phys_addr_out, status
//  apb     | in        | psel/penable, pready | paddr, pwdata, pwrite, prdata
//
// Reset: the store is swept to zero, one entry per cycle, all TABLE_COUNT*512 entries
// (8192 here) with i_req.ready low; register writes still land meanwhile.
// Each level read spends an address state (S_READ, or S_LEAF for the leaf) and a data
// state (S_CHECK); missing levels are allocated in S_ALLOC, then map writes the leaf in
// S_LEAF; misaligned maps and an exhausted pool go straight to the done state.
// The next request may transfer with the result; a stalled o_rsp holds the item in done.
module four_level_page_table_mapper import pgmap_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pgmap_req_if.sink          i_req,
    pgmap_rsp_if.source        o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [FRAME_W-1:0] pool_base;
    t_mem_req           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;

    // Pool base frame register
    pgmap_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_pool_base (pool_base)
    );

    // Sequencer owns the store port and the shared frame adder
    pgmap_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_pool_base (pool_base),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    // TABLE_COUNT tables of 512 entries; table 0 is the root
    pgmap_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- dv/four_level_page_table_mapper_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for four_level_page_table_mapper: map/translate walks, pool
// allocation, misaligned and pool-exhausted items, pool base changes over the APB port.
// Depends on pgmap_pkg, pgmap_req_if, pgmap_rsp_if and the mapper RTL.
module four_level_page_table_mapper_test;
    import pgmap_pkg::*;

    // Cycles with no transfer at all before the run is declared hung. The store
    // sweep after reset passes with no item transfers.
    localparam int QUIET_LIMIT   = 50000;
    // Extra wait after the last result before the next phase starts.
    localparam int SETTLE_CYCLES = 16;
    localparam logic [FRAME_W-1:0] BASE_TOP       = '1;
    localparam logic [ADDR_W-1:0]  PAGE_ADDR_MASK = 48'hFFFF_FFFF_F000;

    typedef struct {
        logic               mode;
        logic [ADDR_W-1:0]  va;
        logic [ADDR_W-1:0]  pa;
        logic [FLAGS_W-1:0] flags;
    } t_walk_req;

    typedef struct {
        logic [ADDR_W-1:0] phys;
        t_status           status;
    } t_walk_rsp;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [CFG_AW-1:0]  paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pgmap_req_if walk_req();
    pgmap_rsp_if walk_rsp();

    four_level_page_table_mapper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (walk_req),
        .o_rsp   (walk_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: table store, bump allocator, pool base register
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] pool_mem [MEM_DEPTH];
    logic [FRAME_W-1:0] pool_base;
    int                 alloc_next;

    t_walk_req          walk_reqs[$];       // items waiting for the driver
    t_walk_rsp          predicted_rsps[$];  // expected results, oldest first
    logic [ADDR_W-1:0]  mapped_pages[$];    // recent map targets, reused for deep walks

    int  items_queued  = 0;
    int  results_seen  = 0;
    int  errors        = 0;
    int  quiet_cycles  = 0;
    int  n_translate   = 0;
    int  n_ok          = 0;
    int  n_misalign    = 0;
    int  n_exhaust     = 0;
    int  n_base_writes = 0;
    bit  idle_on       = 1'b1;
    int  send_gap      = 0;
    int  rsp_hold      = 0;

    // Store slot of the entry that va selects at a given level of table tbl.
    function automatic int slot_of(input int tbl, input logic [ADDR_W-1:0] va, input int lvl);
        logic [ADDR_W-1:0] idx;
        idx = (va >> (PAGE_SHIFT + IDX_W * (int'(LVL_LEAF) - lvl))) & ADDR_W'(ENTRIES - 1);
        return tbl * ENTRIES + int'(idx);
    endfunction

    // One item through the shadow. A dry walk first decides the status; only
    // then are the missing levels allocated and linked, and the leaf touched.
    function automatic t_walk_rsp walk_tables(input logic mode, input logic [ADDR_W-1:0] va,
                                              input logic [ADDR_W-1:0] pa,
                                              input logic [FLAGS_W-1:0] flags);
        t_walk_rsp          r;
        logic [ENTRY_W-1:0] ent;
        logic [FRAME_W-1:0] rel;
        logic [FRAME_W-1:0] frame;
        int                 tbl;
        int                 need;
        int                 first_missing;
        int                 fresh;
        int                 lvl;
        r.phys   = '0;
        r.status = ST_OK;
        if (mode == MODE_MAP && (va[PAGE_SHIFT-1:0] != 0 || pa[PAGE_SHIFT-1:0] != 0)) begin
            r.status = ST_MISALIGN;
            return r;
        end
        tbl           = 0;
        need          = 0;
        first_missing = int'(LVL_LEAF);
        for (lvl = 0; lvl < int'(LVL_LEAF); lvl++) begin
            ent = pool_mem[slot_of(tbl, va, lvl)];
            if (!ent[PRESENT_BIT]) begin
                first_missing = lvl;
                need          = int'(LVL_LEAF) - lvl;
                break;
            end
            // present link must land on an allocated table of the current pool
            rel = ent[ADDR_W-1:PAGE_SHIFT] - pool_base;
            if (rel >= FRAME_W'(alloc_next) || rel >= FRAME_W'(TABLE_COUNT)) begin
                r.status = ST_EXHAUST;
                return r;
            end
            tbl = int'(rel);
        end
        if (need > TABLE_COUNT - alloc_next) begin
            r.status = ST_EXHAUST;
            return r;
        end
        for (lvl = first_missing; lvl < int'(LVL_LEAF); lvl++) begin
            fresh = alloc_next;
            alloc_next++;
            frame = pool_base + FRAME_W'(fresh);
            pool_mem[slot_of(tbl, va, lvl)] = {{(ENTRY_W-ADDR_W){1'b0}}, frame, {PAGE_SHIFT{1'b0}}}
                                              | ENTRY_W'(1);
            tbl = fresh;
        end
        if (mode == MODE_MAP) begin
            pool_mem[slot_of(tbl, va, int'(LVL_LEAF))] = ENTRY_W'(pa) | ENTRY_W'(flags);
        end else begin
            ent    = pool_mem[slot_of(tbl, va, int'(LVL_LEAF))];
            r.phys = ent[ADDR_W-1:0] & PAGE_ADDR_MASK;
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [ENTRY_W-1:0] want,
                                          input logic [ENTRY_W-1:0] got);
        errors++;
        if (errors <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly short gaps, now and then a long one; none while idling is off.
    function automatic int rand_idle();
        int p;
        if (!idle_on)
            return 0;
        p = $urandom_range(99, 0);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic queue_req(input logic mode, input logic [ADDR_W-1:0] va,
                             input logic [ADDR_W-1:0] pa, input logic [FLAGS_W-1:0] flags);
        t_walk_req r;
        r.mode  = mode;
        r.va    = va;
        r.pa    = pa;
        r.flags = flags;
        walk_reqs.push_back(r);
        items_queued++;
        if (mode == MODE_MAP && va[PAGE_SHIFT-1:0] == 0 && pa[PAGE_SHIFT-1:0] == 0) begin
            mapped_pages.push_back(va);
            if (mapped_pages.size() > 48)
                void'(mapped_pages.pop_front());
        end
    endtask

    // Random items: most reuse the path of an earlier map (same page, same
    // last-level table, same upper table), the rest are fresh paths and
    // misaligned maps.
    task automatic queue_random(input int count);
        logic               mode;
        logic [ADDR_W-1:0]  va;
        logic [ADDR_W-1:0]  pa;
        logic [ADDR_W-1:0]  anchor;
        int                 pick;
        repeat (count) begin
            mode   = logic'($urandom_range(1, 0));
            pa     = rand48() & PAGE_ADDR_MASK;
            anchor = (mapped_pages.size() > 0) ?
                     mapped_pages[$urandom_range(mapped_pages.size() - 1, 0)] : rand48();
            pick   = $urandom_range(99, 0);
            if (pick < 25)
                va = anchor & PAGE_ADDR_MASK;
            else if (pick < 60)
                va = {anchor[47:21], 9'($urandom), 12'h000};
            else if (pick < 75)
                va = {anchor[47:30], 18'($urandom), 12'h000};
            else
                va = rand48() & PAGE_ADDR_MASK;
            if (mode == MODE_XLATE)
                va[PAGE_SHIFT-1:0] = 12'($urandom);
            if (pick >= 90) begin
                // broken map: junk in the page offset of va, pa or both
                mode = MODE_MAP;
                va   = (pick < 94) ? rand48() : va;
                pa   = (pick >= 97) ? pa : rand48();
                if (va[PAGE_SHIFT-1:0] == 0 && pa[PAGE_SHIFT-1:0] == 0)
                    va[0] = 1'b1;
            end
            queue_req(mode, va, pa, 8'($urandom));
        end
    endtask

    // Block is idle once every queued item has returned its result.
    task automatic wait_idle();
        while (results_seen != items_queued)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the pool base, then read it back over the same port.
    task automatic set_pool_base(input logic [FRAME_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POOL_BASE;
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pool_base = val;
        n_base_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_W'(val))
            note_mismatch("pool base readback", PDATA_W'(val), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Request driver: next item goes out once the previous one transferred
    // and its trailing gap has run down.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_walk_req nxt;
        if (!i_rst_n) begin
            walk_req.valid <= 1'b0;
            send_gap       <= 0;
        end else if (!walk_req.valid || walk_req.ready) begin
            if (send_gap != 0 || walk_reqs.size() == 0) begin
                walk_req.valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end else begin
                nxt = walk_reqs.pop_front();
                walk_req.valid        <= 1'b1;
                walk_req.mode         <= nxt.mode;
                walk_req.virt_addr    <= nxt.va;
                walk_req.phys_addr_in <= nxt.pa;
                walk_req.entry_flags  <= nxt.flags;
                send_gap              <= rand_idle();
            end
        end
    end

    // Result back-pressure: ready drops for random stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            walk_rsp.ready <= 1'b0;
            rsp_hold       <= 0;
        end else if (rsp_hold != 0) begin
            walk_rsp.ready <= 1'b0;
            rsp_hold       <= rsp_hold - 1;
        end else begin
            walk_rsp.ready <= 1'b1;
            if ($urandom_range(3, 0) == 0)
                rsp_hold <= rand_idle();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result transfers against the oldest prediction, then
    // predict for a request transfer at the same edge. Also the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_walk_rsp want;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (walk_rsp.valid && walk_rsp.ready) begin
                moved = 1'b1;
                results_seen++;
                if (predicted_rsps.size() == 0) begin
                    note_mismatch("unexpected result", '0, ENTRY_W'(walk_rsp.phys_addr_out));
                end else begin
                    want = predicted_rsps.pop_front();
                    if (walk_rsp.phys_addr_out !== want.phys)
                        note_mismatch("phys_addr_out", ENTRY_W'(want.phys),
                                      ENTRY_W'(walk_rsp.phys_addr_out));
                    if (walk_rsp.status !== want.status)
                        note_mismatch("status", ENTRY_W'(want.status),
                                      ENTRY_W'(walk_rsp.status));
                    case (want.status)
                        ST_OK:       n_ok++;
                        ST_MISALIGN: n_misalign++;
                        default:     n_exhaust++;
                    endcase
                end
            end
            if (walk_req.valid && walk_req.ready) begin
                moved = 1'b1;
                if (walk_req.mode == MODE_XLATE)
                    n_translate++;
                predicted_rsps.push_back(walk_tables(walk_req.mode, walk_req.virt_addr,
                                                     walk_req.phys_addr_in,
                                                     walk_req.entry_flags));
            end
            if (psel && penable && pready)
                moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        walk_req.valid        = 1'b0;
        walk_req.mode         = MODE_MAP;
        walk_req.virt_addr    = '0;
        walk_req.phys_addr_in = '0;
        walk_req.entry_flags  = '0;
        walk_rsp.ready        = 1'b0;
        for (int i = 0; i < MEM_DEPTH; i++)
            pool_mem[i] = '0;
        alloc_next = 1;
        pool_base  = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pool base at its top value: table 0 sits at the last frame, table 1
        // wraps to frame zero. The writes land during the clearing sweep.
        set_pool_base(BASE_TOP);

        // translate on an empty store still builds the path (tables 1..3)
        queue_req(MODE_XLATE, 48'h0000_0000_0000, '0, 8'h00);
        queue_req(MODE_MAP,   48'h0000_0000_0000, 48'hFFFF_FFFF_F000, 8'hFF);
        queue_req(MODE_XLATE, 48'h0000_0000_0FFF, '0, 8'h00);
        // all index bits set (tables 4..6)
        queue_req(MODE_MAP,   48'hFFFF_FFFF_F000, 48'h0000_0000_1000, 8'h01);
        queue_req(MODE_XLATE, 48'hFFFF_FFFF_FFFF, '0, 8'h00);
        // misaligned maps: va, pa, both
        queue_req(MODE_MAP,   48'h0000_0000_1001, 48'h0000_0000_0000, 8'h00);
        queue_req(MODE_MAP,   48'h0000_0000_2000, 48'h0000_0000_0800, 8'h00);
        queue_req(MODE_MAP,   48'h0000_0000_3FFF, 48'h0000_0000_0FFF, 8'hFF);
        // translate ignores the page offset
        queue_req(MODE_XLATE, 48'h0000_0000_0ABC, '0, 8'h00);
        queue_req(MODE_MAP,   48'h0000_0000_2000, 48'h0000_5555_5000, 8'hAA);
        queue_req(MODE_XLATE, 48'h0000_0000_2FFF, '0, 8'h00);
        // new top-level slots (tables 7..9, 10..12), then a new upper slot (13, 14)
        queue_req(MODE_MAP,   48'h0080_0000_0000, 48'hAAAA_AAAA_A000, 8'h55);
        queue_req(MODE_MAP,   48'h0100_0000_0000, 48'h1234_5678_9000, 8'h80);
        queue_req(MODE_MAP,   48'h0001_4000_0000, 48'h0000_0000_7000, 8'h7F);
        // one table left, three needed: pool exhausted in both modes
        queue_req(MODE_MAP,   48'h0180_0000_0000, 48'h0000_0000_8000, 8'h01);
        queue_req(MODE_XLATE, 48'h0180_0000_0123, '0, 8'h00);
        // page mapped just above, then a remap of page zero to frame zero
        queue_req(MODE_XLATE, 48'h0001_4000_0000, '0, 8'h00);
        queue_req(MODE_MAP,   48'h0000_0000_0000, 48'h0000_0000_0000, 8'h00);
        queue_req(MODE_XLATE, 48'h0000_0000_0000, '0, 8'h00);
        queue_random(430);
        wait_idle();

        // Base zero shifts every link down one table, so links resolve to the
        // wrong table. No idling in this phase.
        set_pool_base('0);
        idle_on = 1'b0;
        queue_random(150);
        wait_idle();
        idle_on = 1'b1;

        // Arbitrary base: nearly every present link is outside the pool.
        set_pool_base({4'($urandom), 32'($urandom)});
        queue_random(80);
        wait_idle();

        // Back to the base the tables were built with; sender pauses halfway
        // until every result is in.
        set_pool_base(BASE_TOP);
        queue_random(240);
        wait_idle();
        queue_random(240);
        wait_idle();

        errors += predicted_rsps.size();
        $display("Checked %0d results (%0d translates) over %0d pool base settings:",
                 results_seen, n_translate, n_base_writes);
        $display("  %0d ok, %0d misaligned, %0d pool exhausted; %0d of %0d tables in use",
                 n_ok, n_misalign, n_exhaust, alloc_next, TABLE_COUNT);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
